// ===== src/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared widths, constants and the state and result types of the decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	// Width of the running character counter; it saturates at all ones.
	localparam int unsigned INDEX_BITS = 16;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CODE_W      = 21;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned UNIT_W      = 16;
	localparam int unsigned LEN_W       = 3;
	localparam int unsigned CHAR_IDX_W  = 16;

	localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

	// Sequence lengths in bytes
	localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
	localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

	// Code points from this value on need a surrogate pair
	localparam logic [CODE_W-1:0] SUPP_BASE = 21'h10000;

	// Surrogate prefixes; the bases 0xD800 and 0xDC00 have ten zero low bits
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	typedef struct packed {
		logic [1:0]            pending;
		logic [LEN_W-1:0]      seq_len;
		logic [CODE_W-1:0]     partial;
		logic [INDEX_BITS-1:0] counter;
	} state_t;

	typedef struct packed {
		logic [CODE_W-1:0]     code_point;
		logic [WORD_W-1:0]     utf16_word;
		logic                  is_pair;
		logic [LEN_W-1:0]      byte_length;
		logic [CHAR_IDX_W-1:0] char_index;
	} result_t;

endpackage

// ===== src/u8u16_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder step
// Combinational per-byte update of the decoder state and the completed
// character, with its UTF-16 form.
// ----------------------------------------------------------------------------
module u8u16_core (
	input  u8u16_pkg::state_t                    state,
	input  logic [u8u16_pkg::BYTE_W-1:0]         data_byte,
	output u8u16_pkg::state_t                    next_state,
	output logic                                 emit,
	output u8u16_pkg::result_t                   result
);
	import u8u16_pkg::*;

	logic [CODE_W-1:0] cont_code;
	logic [1:0]        pending_dec;
	logic [CODE_W-1:0] emit_code;
	logic [LEN_W-1:0]  emit_len;
	logic [CODE_W-1:0] supp_off;

	assign cont_code   = {state.partial[CODE_W-7:0], data_byte[5:0]};
	assign pending_dec = state.pending - 2'd1;

	always_comb begin
		next_state = state;
		emit       = 1'b0;
		emit_code  = cont_code;
		emit_len   = state.seq_len;
		priority if (data_byte == '0) begin
			next_state = '0;
		end else if (!data_byte[7]) begin
			next_state.pending = '0;
			next_state.seq_len = '0;
			next_state.partial = '0;
			emit      = 1'b1;
			emit_code = CODE_W'(data_byte);
			emit_len  = LEN_ONE;
		end else if (data_byte[7:5] == 3'b110) begin
			next_state.pending = 2'd1;
			next_state.seq_len = LEN_TWO;
			next_state.partial = CODE_W'(data_byte[4:0]);
		end else if (data_byte[7:4] == 4'b1110) begin
			next_state.pending = 2'd2;
			next_state.seq_len = LEN_THREE;
			next_state.partial = CODE_W'(data_byte[3:0]);
		end else if (data_byte[7:3] == 5'b11110) begin
			next_state.pending = 2'd3;
			next_state.seq_len = LEN_FOUR;
			next_state.partial = CODE_W'(data_byte[2:0]);
		end else if (data_byte[7:6] == 2'b10 && state.pending != '0) begin
			if (pending_dec == '0) begin
				next_state.pending = '0;
				next_state.seq_len = '0;
				next_state.partial = '0;
				emit = 1'b1;
			end else begin
				next_state.pending = pending_dec;
				next_state.partial = cont_code;
			end
		end else begin
			// stray continuation or 0xF8..0xFF: leave everything as it is
			next_state = state;
		end

		if (emit && state.counter != INDEX_MAX) begin
			next_state.counter = state.counter + 1'b1;
		end
		if (data_byte == '0) begin
			next_state.counter = '0;
		end
	end

	assign supp_off = emit_code - SUPP_BASE;

	always_comb begin
		result.code_point  = emit_code;
		result.byte_length = emit_len;
		result.char_index  = CHAR_IDX_W'(state.counter);
		if (emit_code < SUPP_BASE) begin
			result.is_pair    = 1'b0;
			result.utf16_word = WORD_W'(emit_code[UNIT_W-1:0]);
		end else begin
			result.is_pair    = 1'b1;
			result.utf16_word = {HIGH_SURR_TAG, supp_off[19:10],
				LOW_SURR_TAG, supp_off[9:0]};
		end
	end

endmodule

// ===== src/utf8_to_utf16_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// Streaming UTF-8 to UTF-16 decoder
// Takes one UTF-8 byte per transfer and gives one result per completed
// character: code point, UTF-16 unit or surrogate pair, length and index.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Payload
//  -------   -----------------   -------------------------------------------
//  input     in_valid/in_ready   data_byte[7:0]
//  output    out_valid/out_ready code_point[20:0], utf16_word[31:0], is_pair,
//                                byte_length[2:0], char_index[15:0]
//
// One byte per cycle sustained while out_ready keeps the result register free. A byte
// is captured in the input register, is decoded there against the state registers,
// and its character (if any) lands in the result register, which drives out_valid.
// Reset clears the state, the counter and both valid flags; no clearing pass.
// While a result waits for out_ready the input register still drains bytes
// that complete no character; a byte that completes one holds until the
// result register frees, and in_ready then falls once the input register is full.
//
module utf8_to_utf16_stream_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [u8u16_pkg::BYTE_W-1:0]          data_byte,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [u8u16_pkg::CODE_W-1:0]          code_point,
	output logic [u8u16_pkg::WORD_W-1:0]          utf16_word,
	output logic                                  is_pair,
	output logic [u8u16_pkg::LEN_W-1:0]           byte_length,
	output logic [u8u16_pkg::CHAR_IDX_W-1:0]      char_index
);
	import u8u16_pkg::*;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// decoder state
	state_t            state_q;
	state_t            state_next;
	logic              emit;
	result_t           result;

	// result register
	logic              out_valid_q;
	result_t           result_q;

	logic              out_free;
	logic              advance;

	// The result register is free when empty or being taken this cycle.
	// A byte that completes no character leaves the result register alone,
	// so let it advance even while a result is stalled.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (out_free || !emit);
	assign in_ready = !valid_s1 || advance;

	u8u16_core u_core (
		.state      (state_q),
		.data_byte  (byte_s1),
		.next_state (state_next),
		.emit       (emit),
		.result     (result)
	);

	// Control state and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				state_q <= state_next;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: capture the byte on transfer, the result when one completes
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
		if (advance && emit) begin
			result_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_point  = result_q.code_point;
	assign utf16_word  = result_q.utf16_word;
	assign is_pair     = result_q.is_pair;
	assign byte_length = result_q.byte_length;
	assign char_index  = result_q.char_index;

endmodule

// ===== src/u8u16_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder checker
// Port-level assertions on the decoder's result channel, bound to the top.
// ----------------------------------------------------------------------------
module u8u16_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic [u8u16_pkg::CODE_W-1:0]          code_point,
	input  logic [u8u16_pkg::WORD_W-1:0]          utf16_word,
	input  logic                                  is_pair,
	input  logic [u8u16_pkg::LEN_W-1:0]           byte_length,
	input  logic [u8u16_pkg::CHAR_IDX_W-1:0]      char_index
);
	import u8u16_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point)
			&& $stable(utf16_word) && $stable(char_index))
		else $error("result changed while stalled");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_length == LEN_ONE || byte_length == LEN_TWO
			|| byte_length == LEN_THREE || byte_length == LEN_FOUR))
		else $error("byte_length out of range");

	a_single_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_pair |-> code_point < SUPP_BASE
			&& utf16_word == WORD_W'(code_point))
		else $error("single unit does not match code point");

	a_pair_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_pair |-> code_point >= SUPP_BASE && byte_length != LEN_ONE
			&& utf16_word[31:26] == HIGH_SURR_TAG && utf16_word[15:10] == LOW_SURR_TAG)
		else $error("malformed surrogate pair");

	a_ascii_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_length == LEN_ONE |-> code_point[CODE_W-1:7] == '0
			&& code_point != '0)
		else $error("one-byte character outside 0x01..0x7F");

endmodule

bind utf8_to_utf16_stream_decoder u8u16_checker u_checker (.*);

// ===== tb/tb_utf8_to_utf16_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// Testbench for the streaming UTF-8 to UTF-16 decoder
// Drives UTF-8 bytes over the valid/ready input channel and checks every
// decoded character against a cycle-free decoder model kept in a scoreboard.
// It runs directed bytes, a long string at full rate, and bursty random
// well-formed and broken sequences.
// ----------------------------------------------------------------------------

module tb_utf8_to_utf16_stream_decoder;

	localparam logic [7:0] NUL_BYTE  = 8'h00;
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] LEAD2_MIN = 8'hC0;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;
	localparam logic [15:0] HIGH_BASE = 16'hD800;
	localparam logic [15:0] LOW_BASE  = 16'hDC00;

	// Tally that ends the random phase, mostly counted in bytes; stray and invalid bytes sent on purpose do not count
	localparam int unsigned RANDOM_ITEMS = 560;
	// One-byte characters in the long string sent at full rate
	localparam int unsigned LONG_CHARS = 40;
	// Idle cycles after the last drain before the final check
	localparam int unsigned SETTLE_CYCLES = 8;

	// Directed opening: extremes, one of each length, and the odd cases
	localparam logic [7:0] OPENING [26] = '{
		8'h01, 8'h7F, 8'h00,                    // smallest and largest ASCII, end of string
		8'hC0, 8'h80,                           // overlong form of code point zero
		8'hE2, 8'h82, 8'hAC,                    // three-byte character
		8'hED, 8'hA0, 8'h80,                    // surrogate code point, given as one unit
		8'hF0, 8'h9F, 8'h98, 8'h80,             // supplementary plane, surrogate pair
		8'hF7, 8'hBF, 8'hBF, 8'hBF,             // largest value, beyond the Unicode range
		8'h80,                                  // stray continuation, ignored
		8'hE2, 8'hFF, 8'h82, 8'hAC,             // invalid byte inside an open sequence
		8'hC2, 8'h41                            // ASCII abandons an open sequence
	};

	class char_scoreboard;

		logic [1:0]                        pending;
		logic [u8u16_pkg::LEN_W-1:0]       seq_len;
		logic [u8u16_pkg::CODE_W-1:0]      partial;
		logic [u8u16_pkg::INDEX_BITS-1:0]  counter;
		u8u16_pkg::result_t                expected_chars[$];
		int unsigned                       errors;

		function new();
			pending = '0;
			seq_len = '0;
			partial = '0;
			counter = '0;
			errors  = 0;
		endfunction

		function void drop_sequence();
			pending = '0;
			seq_len = '0;
			partial = '0;
		endfunction

		// Build the UTF-16 form of a finished character and advance the index
		function void queue_char(logic [u8u16_pkg::CODE_W-1:0] cp,
				logic [u8u16_pkg::LEN_W-1:0] len);
			u8u16_pkg::result_t r;
			logic [u8u16_pkg::CODE_W-1:0] offset;
			r.code_point  = cp;
			r.byte_length = len;
			r.char_index  = counter[u8u16_pkg::CHAR_IDX_W-1:0];
			if (cp < u8u16_pkg::SUPP_BASE) begin
				r.utf16_word = {16'h0000, cp[15:0]};
				r.is_pair    = 1'b0;
			end else begin
				offset       = cp - u8u16_pkg::SUPP_BASE;
				r.utf16_word = {HIGH_BASE | {6'd0, offset[19:10]},
					LOW_BASE | {6'd0, offset[9:0]}};
				r.is_pair    = 1'b1;
			end
			if (counter != u8u16_pkg::INDEX_MAX)
				counter++;
			expected_chars.insert(expected_chars.size(), r);
		endfunction

		// Note one accepted byte and queue the character it completes, if any
		function void decode_byte(logic [7:0] b);
			if (b == NUL_BYTE) begin
				drop_sequence();
				counter = '0;
			end else if (b <= ASCII_MAX) begin
				drop_sequence();
				queue_char({13'd0, b}, u8u16_pkg::LEN_ONE);
			end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
				pending = 2'd1;
				seq_len = u8u16_pkg::LEN_TWO;
				partial = {16'd0, b[4:0]};
			end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
				pending = 2'd2;
				seq_len = u8u16_pkg::LEN_THREE;
				partial = {17'd0, b[3:0]};
			end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
				pending = 2'd3;
				seq_len = u8u16_pkg::LEN_FOUR;
				partial = {18'd0, b[2:0]};
			end else if (b < LEAD2_MIN && pending != 2'd0) begin
				partial = {partial[14:0], b[5:0]};
				pending--;
				if (pending == 2'd0) begin
					queue_char(partial, seq_len);
					drop_sequence();
				end
			end
		endfunction

		function int unsigned outstanding();
			return expected_chars.size();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_char(u8u16_pkg::result_t got);
			u8u16_pkg::result_t want;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character, expected none actual code_point %h",
					$time, got.code_point);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			compare_field("code_point", 32'(want.code_point), 32'(got.code_point));
			compare_field("utf16_word", want.utf16_word, got.utf16_word);
			compare_field("is_pair", 32'(want.is_pair), 32'(got.is_pair));
			compare_field("byte_length", 32'(want.byte_length), 32'(got.byte_length));
			compare_field("char_index", 32'(want.char_index), 32'(got.char_index));
		endfunction

	endclass

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_ROTATE} rx_mode_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid;
	logic                                 in_ready;
	logic [u8u16_pkg::BYTE_W-1:0]         data_byte;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic [u8u16_pkg::CODE_W-1:0]         code_point;
	logic [u8u16_pkg::WORD_W-1:0]         utf16_word;
	logic                                 is_pair;
	logic [u8u16_pkg::LEN_W-1:0]          byte_length;
	logic [u8u16_pkg::CHAR_IDX_W-1:0]     char_index;

	char_scoreboard      sb;
	u8u16_pkg::result_t  seen_char;

	// Sender burst control and receiver stall control
	bit           bursty;
	int unsigned  burst_left;
	bit           rx_free;
	rx_mode_t     rx_mode = RX_OPEN;
	int unsigned  rx_left = 0;
	logic [7:0]   rx_pattern = 8'h01;

	utf8_to_utf16_stream_decoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.utf16_word  (utf16_word),
		.is_pair     (is_pair),
		.byte_length (byte_length),
		.char_index  (char_index)
	);

	always #2 clk = ~clk;

	// Receiver: hold out_ready per mode, switching mode after a random stretch.
	// The rotating pattern always has one bit set, so no stall lasts forever.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_free) begin
			out_ready <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode    = rx_mode_t'($urandom_range(0, 2));
				rx_left    = $urandom_range(8, 40);
				rx_pattern = 8'($urandom) | 8'h01;
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN: begin
					out_ready <= 1'b1;
				end
				RX_COIN: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					out_ready  <= rx_pattern[0];
					rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
				end
			endcase
		end
	end

	// Monitor: note each input transfer, check each output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.decode_byte(data_byte);
			if (out_valid && out_ready) begin
				seen_char.code_point  = code_point;
				seen_char.utf16_word  = utf16_word;
				seen_char.is_pair     = is_pair;
				seen_char.byte_length = byte_length;
				seen_char.char_index  = char_index;
				sb.check_char(seen_char);
			end
		end
	end

	// Offer one byte and hold it until transferred; in bursty mode open a
	// random gap (sometimes none) whenever the current burst runs out.
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		if (bursty) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					@(negedge clk);
					in_valid  <= 1'b0;
					data_byte <= 8'($urandom);
					repeat (gap - 1) @(negedge clk);
				end
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic push_lead(input int len);
		case (len)
			1: push_byte(8'($urandom_range(1, 127)));
			2: push_byte(LEAD2_MIN | 8'($urandom_range(0, 31)));
			3: push_byte(LEAD3_MIN | 8'($urandom_range(0, 15)));
			default: push_byte(LEAD4_MIN | 8'($urandom_range(0, 7)));
		endcase
	endtask

	task automatic push_cont();
		push_byte(CONT_TAG | 8'($urandom_range(0, 63)));
	endtask

	// Lower valid and wait until every queued character has come out
	task automatic drain_chars();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned counted;
		int unsigned pick;
		int          len;
		bit          paused;

		sb         = new();
		in_valid   = 1'b0;
		data_byte  = '0;
		bursty     = 1'b0;
		burst_left = 0;
		rx_free    = 1'b0;
		counted    = 0;
		paused     = 1'b0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed bytes, sent back to back into a stalling receiver
		foreach (OPENING[i])
			push_byte(OPENING[i]);
		drain_chars();

		// One long string at full rate, then end it and confirm the index
		// restarts at zero
		rx_free = 1'b1;
		push_byte(NUL_BYTE);
		repeat (LONG_CHARS) push_lead(1);
		push_lead(4);
		repeat (3) push_cont();
		push_lead(2);
		push_cont();
		push_byte(NUL_BYTE);
		push_lead(1);
		drain_chars();
		rx_free = 1'b0;

		// Random phase: mostly well-formed characters, the rest broken or noise
		bursty = 1'b1;
		while (counted < RANDOM_ITEMS) begin
			if (!paused && counted > RANDOM_ITEMS / 2) begin
				// Hold the sender off until the block has emptied
				drain_chars();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			len  = 1;
			case ($urandom_range(0, 9))
				0, 1, 2: len = 1;
				3, 4, 5: len = 2;
				6, 7:    len = 3;
				default: len = 4;
			endcase
			if (pick < 76) begin
				push_lead(len);
				repeat (len - 1) push_cont();
				counted += len;
			end else if (pick < 84) begin
				// Truncated sequence; the next lead, ASCII or NUL byte abandons it
				len = $urandom_range(2, 4);
				push_lead(len);
				repeat ($urandom_range(0, len - 2)) push_cont();
				counted += len - 1;
			end else if (pick < 89) begin
				// Invalid byte inside an open sequence; the sequence survives it
				len = $urandom_range(2, 4);
				push_lead(len);
				push_byte(8'($urandom_range(8'hF8, 8'hFF)));
				repeat (len - 1) push_cont();
				counted += len;
			end else if (pick < 92) begin
				push_cont();
			end else if (pick < 94) begin
				push_byte(8'($urandom_range(8'hF8, 8'hFF)));
			end else if (pick < 97) begin
				push_byte(NUL_BYTE);
				counted++;
			end else begin
				push_byte(8'($urandom));
				counted++;
			end
		end

		drain_chars();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#400000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/u8u16_pkg.sv
src/u8u16_core.sv
src/utf8_to_utf16_stream_decoder.sv
src/u8u16_checker.sv
tb/tb_utf8_to_utf16_stream_decoder.sv
